// ===== hw/rtl/fts_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the bounded fifo tabu set
package fts_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int HASH_WIDTH_DEF = 54;
	localparam int MAXE_W         = 7;
	localparam int OCC_W          = 7;

	typedef enum logic {
		MODE_QUERY = 1'b0,
		MODE_ADD   = 1'b1
	} fts_mode_t;

	typedef struct packed {
		logic             was_present;
		logic             inserted;
		logic             evicted;
		logic [OCC_W-1:0] occupancy;
	} fts_flags_t;

endpackage

// ===== hw/rtl/bounded_fifo_tabu_set.sv =====
`timescale 1ns / 1ps
// path: an accepted transaction waits in stage one and moves into the result
//   register when that register is empty or being drained
// throughput: one transaction per cycle while the receiver does not stall, set by
//   the combinational compare of the hash against every held slot in the store
// reset: arst_n clears the valid bits, count, oldest pointer and max_entries
//   at once; no clearing pass, items are taken right after reset
module bounded_fifo_tabu_set import fts_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write
	input  logic                  wr_en,
	input  logic [MAXE_W-1:0]     wr_data,
	// input transaction
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [HASH_WIDTH-1:0] state_hash,
	// result transaction
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  was_present,
	output logic                  inserted,
	output logic                  evicted,
	output logic [HASH_WIDTH-1:0] evicted_hash,
	output logic [OCC_W-1:0]      occupancy
);

	// limit on held hashes
	logic [MAXE_W-1:0] max_entries_q;

	// stage one holds the accepted transaction
	logic                  valid_s1;
	logic                  mode_s1;
	logic [HASH_WIDTH-1:0] hash_s1;

	// store result feeding the output register
	fts_flags_t            flags;
	logic [HASH_WIDTH-1:0] ev_hash;

	// stage one moves on when the result register is empty or being drained;
	// the store updates on the same edge so the next item sees the new ring
	logic advance;

	assign advance = valid_s1 && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= '0;
		end else if (wr_en) begin
			max_entries_q <= wr_data;
		end
	end

	fts_in_reg #(
		.HASH_WIDTH (HASH_WIDTH)
	) u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.state_hash (state_hash),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.mode_s1    (mode_s1),
		.hash_s1    (hash_s1)
	);

	// ring of slots: membership, insert at the tail, evict at the head
	fts_store #(
		.CAPACITY   (CAPACITY),
		.HASH_WIDTH (HASH_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.mode    (mode_s1),
		.hash    (hash_s1),
		.limit   (max_entries_q),
		.flags   (flags),
		.ev_hash (ev_hash)
	);

	fts_out_reg #(
		.HASH_WIDTH (HASH_WIDTH)
	) u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.flags        (flags),
		.ev_hash      (ev_hash),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.was_present  (was_present),
		.inserted     (inserted),
		.evicted      (evicted),
		.evicted_hash (evicted_hash),
		.occupancy    (occupancy)
	);

endmodule

// ===== hw/rtl/fts_in_reg.sv =====
`timescale 1ns / 1ps
// input register stage of the tabu set
module fts_in_reg import fts_pkg::*; #(
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [HASH_WIDTH-1:0] state_hash,
	input  logic                  advance,
	output logic                  valid_s1,
	output logic                  mode_s1,
	output logic [HASH_WIDTH-1:0] hash_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mode_s1 <= mode;
			hash_s1 <= state_hash;
		end
	end

endmodule

// ===== hw/rtl/fts_store.sv =====
`timescale 1ns / 1ps
// ring of hash slots with parallel compare, insertion and eviction
module fts_store import fts_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  mode,
	input  logic [HASH_WIDTH-1:0] hash,
	input  logic [MAXE_W-1:0]     limit,
	output fts_flags_t            flags,
	output logic [HASH_WIDTH-1:0] ev_hash
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LIM_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

	logic [HASH_WIDTH-1:0] store_q [CAPACITY];
	logic [CAPACITY-1:0]   valid_q;
	logic [PTR_W-1:0]      oldest_q;
	logic [CNT_W-1:0]      count_q;

	logic [CAPACITY-1:0] hit;
	logic                present;
	logic                do_add;
	logic                full;
	logic                over;
	logic                drop;
	logic [LIM_W-1:0]    lim_ext;
	logic [LIM_W-1:0]    lim_eff;
	logic [CNT_W-1:0]    count_inc;
	logic [CNT_W-1:0]    count_next;
	logic [PTR_W:0]      slot_sum;
	logic [PTR_W-1:0]    slot_free;
	logic [PTR_W-1:0]    write_slot;
	logic [PTR_W-1:0]    oldest_inc;
	logic [CAPACITY-1:0] valid_next;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit[i] = valid_q[i] && (store_q[i] == hash);
		end
	end

	assign present = |hit;
	assign do_add  = (mode == MODE_ADD) && !present;
	assign full    = (count_q == CNT_W'(CAPACITY));

	// effective limit is the smaller of the register and the ring size
	assign lim_ext   = LIM_W'(limit);
	assign lim_eff   = (lim_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : lim_ext;
	assign count_inc = count_q + CNT_W'(1);
	assign over      = LIM_W'(count_inc) > lim_eff;
	assign drop      = full || over;

	// first free slot after the held entries, wrapped once
	assign slot_sum   = (PTR_W + 1)'(oldest_q) + (PTR_W + 1)'(count_q);
	assign slot_free  = (slot_sum >= (PTR_W + 1)'(CAPACITY))
		? PTR_W'(slot_sum - (PTR_W + 1)'(CAPACITY)) : PTR_W'(slot_sum);
	assign write_slot = full ? oldest_q : slot_free;
	assign oldest_inc = (oldest_q == PTR_W'(CAPACITY - 1)) ? '0 : oldest_q + PTR_W'(1);
	assign count_next = drop ? count_q : count_inc;

	// new slot marked, oldest cleared on a drop unless the ring is full and the write reuses it
	always_comb begin
		valid_next             = valid_q;
		valid_next[write_slot] = 1'b1;
		if (drop && !full) begin
			valid_next[oldest_q] = 1'b0;
		end
	end

	always_comb begin
		flags.was_present = present;
		flags.inserted    = do_add;
		flags.evicted     = do_add && drop;
		flags.occupancy   = do_add ? OCC_W'(count_next) : OCC_W'(count_q);
		ev_hash           = '0;
		if (do_add && drop) begin
			// an empty ring evicts the hash it just took
			if (count_q == '0) begin
				ev_hash = hash;
			end else begin
				ev_hash = store_q[oldest_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && do_add) begin
			store_q[write_slot] <= hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			count_q  <= '0;
		end else if (step && do_add) begin
			valid_q <= valid_next;
			if (drop) begin
				oldest_q <= oldest_inc;
			end
			count_q <= count_next;
		end
	end

endmodule

// ===== hw/rtl/fts_out_reg.sv =====
`timescale 1ns / 1ps
// result register stage of the tabu set
module fts_out_reg import fts_pkg::*; #(
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  fts_flags_t            flags,
	input  logic [HASH_WIDTH-1:0] ev_hash,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic                  was_present,
	output logic                  inserted,
	output logic                  evicted,
	output logic [HASH_WIDTH-1:0] evicted_hash,
	output logic [OCC_W-1:0]      occupancy
);

	fts_flags_t            flags_s2;
	logic [HASH_WIDTH-1:0] ev_hash_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flags_s2   <= flags;
			ev_hash_s2 <= ev_hash;
		end
	end

	assign was_present  = flags_s2.was_present;
	assign inserted     = flags_s2.inserted;
	assign evicted      = flags_s2.evicted;
	assign occupancy    = flags_s2.occupancy;
	assign evicted_hash = ev_hash_s2;

endmodule
